// ===== sv/iirf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirf_pkg
// Types and constants shared by the direct-form-I IIR filter core.
// ----------------------------------------------------------------------------
package iirf_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int COEF_WIDTH      = 16;
    localparam int FRAC_SHIFT      = 14;
    localparam int MAX_ORDER       = 3;
    localparam int REG_INDEX_WIDTH = 3;

    localparam logic signed [COEF_WIDTH-1:0] B0_RESET = 16'sd16384;

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_B3 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5,
        REG_A3 = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           last_sample;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
        logic                           saturated;
        logic                           last;
    } result_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] b3;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
        logic signed [COEF_WIDTH-1:0] a3;
    } coef_set_t;

    localparam coef_set_t COEF_RESET = '{
        b0: B0_RESET,
        b1: '0,
        b2: '0,
        b3: '0,
        a1: '0,
        a2: '0,
        a3: '0
    };

endpackage
`default_nettype wire

// ===== sv/difference_equation_iir_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// difference_equation_iir_filter_core
// Direct-form-I IIR filter with Q2.14 coefficients, rounded and saturated
// Q1.15 output, and history clearing after the last sample of a sequence.
//
//   Channel   Handshake                  Payload
//   sample    sample_valid/sample_stall  sample_t (sample_in, last_sample)
//   result    result_valid/result_stall  result_t (filtered_sample, ...)
//   config    cfg_wen                    cfg_index, cfg_data
//
// A sample is held in the input register, then the seven
// products, the sum and the saturation are formed in one pass into the
// result register: one transfer per cycle while the result is not stalled.
// The feedback through the output history closes within that single pass.
// Reset clears the histories and loads b0 with 1.0, the others with zero.
// A stalled result holds the pipeline; the input stalls only then.
// ----------------------------------------------------------------------------
module difference_equation_iir_filter_core #(
    parameter int ORDER = 3
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 sample_valid,
    output logic                                      sample_stall,
    input  wire iirf_pkg::sample_t                    sample,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output iirf_pkg::result_t                         result,
    input  wire logic                                 cfg_wen,
    input  wire logic [iirf_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [iirf_pkg::COEF_WIDTH-1:0]      cfg_data
);

    iirf_pkg::coef_set_t coefs;
    iirf_pkg::sample_t   stage_reg;
    iirf_pkg::sample_t   stage_next;
    logic                stage_valid_reg;
    logic                stage_valid_next;
    iirf_pkg::result_t   result_reg;
    iirf_pkg::result_t   result_next;
    iirf_pkg::result_t   computed;
    logic                result_valid_reg;
    logic                result_valid_next;
    logic                advance;
    logic                sample_take;

    iirf_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    iirf_datapath #(
        .ORDER (ORDER)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (stage_reg),
        .coefs   (coefs),
        .result  (computed)
    );

    assign advance      = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = stage_valid_reg && !advance;
    assign sample_take  = sample_valid && !sample_stall;

    always_comb
    begin
        stage_next        = sample_take ? sample : stage_reg;
        stage_valid_next  = sample_take || (stage_valid_reg && !advance);
        result_next       = advance ? computed : result_reg;
        result_valid_next = advance || (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg  <= stage_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    localparam logic signed [iirf_pkg::SAMPLE_WIDTH-1:0] OUT_MAX =
        iirf_pkg::SAMPLE_WIDTH'((2 ** (iirf_pkg::SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [iirf_pkg::SAMPLE_WIDTH-1:0] OUT_MIN = ~OUT_MAX;

    a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid_reg |-> !sample_stall)
        else $error("Input stalled although the result register is empty.");

    a_advance_fills_result : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("Computed sample did not reach the result register.");

    a_last_follows : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_reg.last == $past(stage_reg.last_sample))
        else $error("Last mark lost between input and result register.");

    a_sat_at_limit : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.saturated |->
            (result_reg.filtered_sample == OUT_MAX) ||
            (result_reg.filtered_sample == OUT_MIN))
        else $error("Saturation flag set on a value inside the range.");

endmodule
`default_nettype wire

// ===== sv/iirf_coef_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirf_coef_regs
// Coefficient register file, written through a plain write port.
// ----------------------------------------------------------------------------
module iirf_coef_regs (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_wen,
    input  wire logic [iirf_pkg::REG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [iirf_pkg::COEF_WIDTH-1:0]         cfg_data,
    output iirf_pkg::coef_set_t                          coefs
);

    iirf_pkg::coef_set_t coef_reg;
    iirf_pkg::coef_set_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                iirf_pkg::REG_B0: coef_next.b0 = $signed(cfg_data);
                iirf_pkg::REG_B1: coef_next.b1 = $signed(cfg_data);
                iirf_pkg::REG_B2: coef_next.b2 = $signed(cfg_data);
                iirf_pkg::REG_B3: coef_next.b3 = $signed(cfg_data);
                iirf_pkg::REG_A1: coef_next.a1 = $signed(cfg_data);
                iirf_pkg::REG_A2: coef_next.a2 = $signed(cfg_data);
                iirf_pkg::REG_A3: coef_next.a3 = $signed(cfg_data);
                default:          coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= iirf_pkg::COEF_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule
`default_nettype wire

// ===== sv/iirf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirf_datapath
// Multiply-accumulate, rounding and saturation for one sample, with the
// input and output history registers.
// ----------------------------------------------------------------------------
module iirf_datapath #(
    parameter int ORDER = 3
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire iirf_pkg::sample_t     sample,
    input  wire iirf_pkg::coef_set_t   coefs,
    output iirf_pkg::result_t          result
);

    localparam int SW     = iirf_pkg::SAMPLE_WIDTH;
    localparam int CW     = iirf_pkg::COEF_WIDTH;
    localparam int FRAC   = iirf_pkg::FRAC_SHIFT;
    localparam int PROD_W = SW + CW;
    localparam int ACC_W  = PROD_W + 3;
    localparam int Y_W    = ACC_W - FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC - 1);
    localparam logic signed [Y_W-1:0]   SMAX       = Y_W'((2 ** (SW - 1)) - 1);
    localparam logic signed [Y_W-1:0]   SMIN       = ~SMAX;

    logic signed [SW-1:0] x_hist_reg  [0:ORDER-1];
    logic signed [SW-1:0] y_hist_reg  [0:ORDER-1];
    logic signed [SW-1:0] x_hist_next [0:ORDER-1];
    logic signed [SW-1:0] y_hist_next [0:ORDER-1];

    logic signed [CW-1:0]    b_coef [0:iirf_pkg::MAX_ORDER];
    logic signed [CW-1:0]    a_coef [1:iirf_pkg::MAX_ORDER];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_rounded;
    logic signed [Y_W-1:0]   y_wide;
    logic signed [SW-1:0]    y_sat;
    logic                    sat;

    always_comb
    begin
        b_coef[0] = coefs.b0;
        b_coef[1] = coefs.b1;
        b_coef[2] = coefs.b2;
        b_coef[3] = coefs.b3;
        a_coef[1] = coefs.a1;
        a_coef[2] = coefs.a2;
        a_coef[3] = coefs.a3;
    end

    always_comb
    begin
        logic signed [PROD_W-1:0] prod_ff;
        logic signed [PROD_W-1:0] prod_fb;
        prod_ff = b_coef[0] * sample.sample_in;
        prod_fb = '0;
        acc     = ACC_W'(prod_ff);
        for (int k = 1; k <= ORDER; k++)
        begin
            prod_ff = b_coef[k] * x_hist_reg[k-1];
            prod_fb = a_coef[k] * y_hist_reg[k-1];
            acc     = acc + ACC_W'(prod_ff) - ACC_W'(prod_fb);
        end
        acc_rounded = acc + ROUND_HALF;
        y_wide      = acc_rounded[ACC_W-1:FRAC];
        if (y_wide > SMAX)
        begin
            y_sat = SMAX[SW-1:0];
            sat   = 1'b1;
        end
        else if (y_wide < SMIN)
        begin
            y_sat = SMIN[SW-1:0];
            sat   = 1'b1;
        end
        else
        begin
            y_sat = y_wide[SW-1:0];
            sat   = 1'b0;
        end
    end

    always_comb
    begin
        for (int k = 0; k < ORDER; k++)
        begin
            x_hist_next[k] = x_hist_reg[k];
            y_hist_next[k] = y_hist_reg[k];
        end
        if (advance)
        begin
            if (sample.last_sample)
            begin
                for (int k = 0; k < ORDER; k++)
                begin
                    x_hist_next[k] = '0;
                    y_hist_next[k] = '0;
                end
            end
            else
            begin
                for (int k = ORDER - 1; k > 0; k--)
                begin
                    x_hist_next[k] = x_hist_reg[k-1];
                    y_hist_next[k] = y_hist_reg[k-1];
                end
                x_hist_next[0] = sample.sample_in;
                y_hist_next[0] = y_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ORDER; k++)
            begin
                x_hist_reg[k] <= '0;
                y_hist_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < ORDER; k++)
            begin
                x_hist_reg[k] <= x_hist_next[k];
                y_hist_reg[k] <= y_hist_next[k];
            end
        end
    end

    assign result.filtered_sample = y_sat;
    assign result.saturated       = sat;
    assign result.last            = sample.last_sample;

endmodule
`default_nettype wire

// ===== tb/iir_output_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_output_checker
// Watches the sample, result and coefficient ports of the IIR filter core,
// keeps its own copy of the coefficients and histories, predicts every
// filter output and compares it field by field with what the core delivers.
// ----------------------------------------------------------------------------
module iir_output_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    input  logic                                 sample_stall,
    input  iirf_pkg::sample_t                    sample,
    input  logic                                 result_valid,
    input  logic                                 result_stall,
    input  iirf_pkg::result_t                    result,
    input  logic                                 cfg_wen,
    input  logic [iirf_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [iirf_pkg::COEF_WIDTH-1:0]      cfg_data,
    output int                                   failures,
    output int                                   pending,
    output int                                   outputs_checked,
    output int                                   clipped_outputs,
    output int                                   sequence_ends
);

    localparam int     SW           = iirf_pkg::SAMPLE_WIDTH;
    localparam int     CW           = iirf_pkg::COEF_WIDTH;
    localparam int     MAX_ORDER    = iirf_pkg::MAX_ORDER;
    localparam longint OUT_MAX      = (longint'(1) << (SW - 1)) - 1;
    localparam longint OUT_MIN      = -OUT_MAX - 1;
    localparam int     REPORT_LIMIT = 10;

    logic signed [CW-1:0]     ff_coef [0:MAX_ORDER];
    logic signed [CW-1:0]     fb_coef [1:MAX_ORDER];
    logic signed [SW-1:0]     x_hist [0:MAX_ORDER-1];
    logic signed [SW-1:0]     y_hist [0:MAX_ORDER-1];
    iirf_pkg::result_t        expected_outputs [$];

    function automatic iirf_pkg::result_t next_filter_output(input iirf_pkg::sample_t item);
        iirf_pkg::result_t    r;
        longint               acc;
        longint               y;
        logic signed [SW-1:0] x;
        x   = $signed(item.sample_in);
        acc = longint'(ff_coef[0]) * longint'(x);
        for (int k = 1; k <= MAX_ORDER; k++)
        begin
            acc += longint'(ff_coef[k]) * longint'(x_hist[k-1]);
            acc -= longint'(fb_coef[k]) * longint'(y_hist[k-1]);
        end
        y = (acc + (longint'(1) << (iirf_pkg::FRAC_SHIFT - 1))) >>> iirf_pkg::FRAC_SHIFT;
        r.saturated = 1'b0;
        if (y > OUT_MAX)
        begin
            y = OUT_MAX;
            r.saturated = 1'b1;
        end
        else if (y < OUT_MIN)
        begin
            y = OUT_MIN;
            r.saturated = 1'b1;
        end
        r.filtered_sample = y[SW-1:0];
        r.last = item.last_sample;
        if (item.last_sample)
        begin
            for (int k = 0; k < MAX_ORDER; k++)
            begin
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
        end
        else
        begin
            for (int k = MAX_ORDER - 1; k > 0; k--)
            begin
                x_hist[k] = x_hist[k-1];
                y_hist[k] = y_hist[k-1];
            end
            x_hist[0] = x;
            y_hist[0] = r.filtered_sample;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        iirf_pkg::result_t want;
        if (!rst_n)
        begin
            ff_coef[0] = iirf_pkg::B0_RESET;
            for (int k = 1; k <= MAX_ORDER; k++)
            begin
                ff_coef[k] = '0;
                fb_coef[k] = '0;
            end
            for (int k = 0; k < MAX_ORDER; k++)
            begin
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
            expected_outputs.delete();
            failures        = 0;
            outputs_checked = 0;
            clipped_outputs = 0;
            sequence_ends   = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    iirf_pkg::REG_B0: ff_coef[0] = cfg_data;
                    iirf_pkg::REG_B1: ff_coef[1] = cfg_data;
                    iirf_pkg::REG_B2: ff_coef[2] = cfg_data;
                    iirf_pkg::REG_B3: ff_coef[3] = cfg_data;
                    iirf_pkg::REG_A1: fb_coef[1] = cfg_data;
                    iirf_pkg::REG_A2: fb_coef[2] = cfg_data;
                    iirf_pkg::REG_A3: fb_coef[3] = cfg_data;
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
                expected_outputs.push_back(next_filter_output(sample));
            if (result_valid && !result_stall)
            begin
                if (expected_outputs.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t: unexpected transfer on result:", $time,
                                 " sample %0d sat %0b last %0b",
                                 $signed(result.filtered_sample), result.saturated,
                                 result.last);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    outputs_checked++;
                    if (want.saturated)
                        clipped_outputs++;
                    if (want.last)
                        sequence_ends++;
                    if (result.filtered_sample !== want.filtered_sample
                        || result.saturated !== want.saturated
                        || result.last !== want.last)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected sample %0d sat %0b last %0b,",
                                     $time, $signed(want.filtered_sample),
                                     want.saturated, want.last,
                                     " got sample %0d sat %0b last %0b",
                                     $signed(result.filtered_sample),
                                     result.saturated, result.last);
                    end
                end
            end
        end
        pending = expected_outputs.size();
    end

endmodule

// ===== tb/tb_difference_equation_iir_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_difference_equation_iir_filter_core
// Drives the IIR filter core with directed corner cases and random sample
// sequences under a series of coefficient sets, with random gaps on the
// sample side and random stalls on the result side; a separate checker
// predicts and compares every output.
// ----------------------------------------------------------------------------
module tb_difference_equation_iir_filter_core;

    localparam int IW = iirf_pkg::REG_INDEX_WIDTH;
    localparam int CW = iirf_pkg::COEF_WIDTH;
    localparam int SW = iirf_pkg::SAMPLE_WIDTH;

    localparam logic [IW-1:0] UNMAPPED_REG = 3'd7;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int DRAIN_CYCLES    = 4;
    localparam int IDLE_LIMIT      = 1000;

    logic              clk;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_stall;
    iirf_pkg::sample_t sample;
    logic              result_valid;
    logic              result_stall;
    iirf_pkg::result_t result;
    logic              cfg_wen;
    logic [IW-1:0]     cfg_index;
    logic [CW-1:0]     cfg_data;

    int   failures;
    int   pending;
    int   outputs_checked;
    int   clipped_outputs;
    int   sequence_ends;
    int   coef_sets;
    int   idle_cycles;
    int   stall_len;
    logic quiet;

    difference_equation_iir_filter_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    iir_output_checker output_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending         (pending),
        .outputs_checked (outputs_checked),
        .clipped_outputs (clipped_outputs),
        .sequence_ends   (sequence_ends)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_len = $urandom_range(1, 3);
                result_stall = 1'b1;
                repeat (stall_len) @(negedge clk);
                result_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_difference_equation_iir_filter_core: FAIL");
            $finish;
        end
    end

    function automatic logic [CW-1:0] pick_coef();
        logic [CW-1:0] value;
        case ($urandom_range(0, 4))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: value = 16'h8000;
                    1: value = 16'h7FFF;
                    2: value = 16'hFFFF;
                    default: value = 16'h0000;
                endcase
            end
            1, 2: value = CW'($urandom);
            3: value = CW'($urandom_range(0, 8192) - 4096);
            default: value = '0;
        endcase
        return value;
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        logic [SW-1:0] value;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: value = 16'h8000;
                    1: value = 16'h7FFF;
                    2: value = 16'hFFFF;
                    default: value = 16'h0000;
                endcase
            end
            1, 2, 3, 4: value = SW'($urandom);
            default: value = SW'($urandom_range(0, 2048) - 1024);
        endcase
        return value;
    endfunction

    task automatic send_sample(input logic [SW-1:0] value, input logic last_mark);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid = 1'b1;
        sample.sample_in = value;
        sample.last_sample = last_mark;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        sample_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_coef(input logic [IW-1:0] index, input logic [CW-1:0] value);
        cfg_wen = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    task automatic load_coefs(input iirf_pkg::coef_set_t c);
        drain();
        write_coef(iirf_pkg::REG_B0, c.b0);
        write_coef(iirf_pkg::REG_B1, c.b1);
        write_coef(iirf_pkg::REG_B2, c.b2);
        write_coef(iirf_pkg::REG_B3, c.b3);
        write_coef(iirf_pkg::REG_A1, c.a1);
        write_coef(iirf_pkg::REG_A2, c.a2);
        write_coef(iirf_pkg::REG_A3, c.a3);
        coef_sets++;
    endtask

    initial
    begin
        iirf_pkg::coef_set_t c;
        int                  seq_left;
        rst_n        = 1'b0;
        quiet        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_wen      = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        coef_sets    = 1;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);

        // Smallest gain: checks rounding half up on both sides of zero.
        c = '0;
        c.b0 = 16'sd1;
        load_coefs(c);
        send_sample(16'sd8192, 1'b0);
        send_sample(16'sd8191, 1'b0);
        send_sample(-16'sd8192, 1'b0);
        send_sample(-16'sd8193, 1'b1);

        c.b0 = 16'h8000;
        c.b1 = 16'h7FFF;
        c.b2 = 16'h8000;
        c.b3 = 16'h7FFF;
        c.a1 = 16'h8000;
        c.a2 = 16'h7FFF;
        c.a3 = 16'h8000;
        load_coefs(c);
        write_coef(UNMAPPED_REG, 16'h5A5A);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b1);

        // Integrator: feedback drives the output into the clip, then the
        // end of the sequence must clear the histories.
        c = '0;
        c.b0 = 16'sd16384;
        c.a1 = -16'sd16384;
        load_coefs(c);
        send_sample(16'sd20000, 1'b0);
        send_sample(16'sd20000, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd100, 1'b1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            c.b0 = pick_coef();
            c.b1 = pick_coef();
            c.b2 = pick_coef();
            c.b3 = pick_coef();
            c.a1 = pick_coef();
            c.a2 = pick_coef();
            c.a3 = pick_coef();
            load_coefs(c);
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            seq_left = $urandom_range(1, 60);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                seq_left--;
                send_sample(pick_sample(), seq_left == 0);
                if (seq_left == 0)
                    seq_left = $urandom_range(1, 60);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d filter outputs over %0d coefficient sets.",
                 outputs_checked, coef_sets);
        $display("%0d outputs were clipped and %0d sequences were closed.",
                 clipped_outputs, sequence_ends);
        if (failures == 0 && pending == 0)
            $display("tb_difference_equation_iir_filter_core: PASS");
        else
            $display("tb_difference_equation_iir_filter_core: FAIL");
        $finish;
    end

endmodule
